### rtl/raster_blit_format_convert_unit_macros.svh
// ---------------------------------------------------------------------------
// Raster blit assertion macros
// Shared concurrent assertion forms for the blit checker.
// ---------------------------------------------------------------------------
`ifndef RASTER_BLIT_FORMAT_CONVERT_UNIT_MACROS_SVH
`define RASTER_BLIT_FORMAT_CONVERT_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RBFC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("raster blit check failed");

// Next-cycle implication, disabled while reset is high.
`define RBFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("raster blit check failed");

`endif

### rtl/rbfc_pkg.sv
// ---------------------------------------------------------------------------
// Raster blit package
// Widths, codes and helpers shared by the blit unit and its checker.
// ---------------------------------------------------------------------------
`default_nettype none

package rbfc_pkg;

  // Geometry limits.
  localparam int MAX_DIM = 4096;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int CNT_W   = $clog2(MAX_DIM);

  // Field widths of the result item.
  localparam int OFF_W  = 24;
  localparam int DATA_W = 32;
  localparam int RUN_W  = 25;
  localparam int STAT_W = 2;
  localparam int PIX_W  = 32;

  // Stream packing.
  localparam int OUT_BITS = OFF_W + DATA_W + RUN_W;
  localparam int TDATA_W  = ((OUT_BITS + 7) / 8) * 8;
  localparam int TUSER_W  = STAT_W + 1;
  localparam int OFF_LSB  = 0;
  localparam int DATA_LSB = OFF_W;
  localparam int RUN_LSB  = OFF_W + DATA_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = DIM_W;
  localparam logic [CFG_IDX_W-1:0] REG_FORMAT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DST_STRIDE = 3'd5;

  // Pixel formats.
  localparam logic [1:0] FMT_RGBA   = 2'd0;
  localparam logic [1:0] FMT_RGBX   = 2'd1;
  localparam logic [1:0] FMT_RGB565 = 2'd2;
  localparam logic [1:0] FMT_BAD    = 2'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_STRIDE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_FORMAT = 2'd2;

  typedef logic [DIM_W-1:0] dim_t;

  // Saturate a size register into the range 1 to MAX_DIM.
  function automatic dim_t clamp_dim(input dim_t v);
    dim_t r;
    if (v == '0) begin
      r = dim_t'(1);
    end else if (v > dim_t'(MAX_DIM)) begin
      r = dim_t'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/raster_blit_format_convert_unit.sv
// ---------------------------------------------------------------------------
// Raster blit format converter
// Converts a row-major source frame into strided destination writes and
// zero-fill runs, with RGBA copy, RGBX and RGB565 un-premultiply modes.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake          Payload
//  s_*      in         s_tvalid/s_tready  s_tdata: src_pixel
//  m_*      out        m_tvalid/m_tready  m_tdata, m_tuser, m_tlast (last_result)
//  cfg_*    in         cfg_we             cfg_index, cfg_data
//
//  Each pixel passes the three multiply states and then emits its results;
//  in RGB565 mode with alpha from 1 to 254 the single shared restoring
//  divider first divides each colour in turn, or saturates it at 255.
//  Reset is synchronous and clears the counters, sequencer and output valid.
//  A stalled output holds its result, and the input waits until the last
//  result of the pixel sits in the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module raster_blit_format_convert_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Configuration write port.
  input  wire logic                             cfg_we,
  input  wire logic [rbfc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rbfc_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Source pixels.
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [rbfc_pkg::PIX_W-1:0]       s_tdata,   // [31:0] src_pixel
  // Destination writes.
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // [23:0] dst_offset, [55:24] pixel_data, [80:56] run_length, [87:81] zero
  output logic [rbfc_pkg::TDATA_W-1:0]          m_tdata,
  output logic [rbfc_pkg::TUSER_W-1:0]          m_tuser,   // [1:0] status, [2] end_of_frame
  output logic                                  m_tlast
);
  import rbfc_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL0  = 3'd1;
  localparam logic [2:0] ST_MUL1  = 3'd2;
  localparam logic [2:0] ST_MUL2  = 3'd3;
  localparam logic [2:0] ST_DLOAD = 3'd4;
  localparam logic [2:0] ST_DSTEP = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  // Configuration registers.
  logic [1:0] pixel_format;
  dim_t       src_cols, src_height, dst_width, dst_height, dst_stride;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_RGBA;
      src_cols     <= dim_t'(1);
      src_height   <= dim_t'(1);
      dst_width    <= dim_t'(1);
      dst_height   <= dim_t'(1);
      dst_stride   <= dim_t'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FORMAT:     pixel_format <= cfg_data[1:0];
        REG_SRC_WIDTH:  src_cols     <= cfg_data;
        REG_SRC_HEIGHT: src_height   <= cfg_data;
        REG_DST_WIDTH:  dst_width    <= cfg_data;
        REG_DST_HEIGHT: dst_height   <= cfg_data;
        REG_DST_STRIDE: dst_stride   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturated geometry and the copy window.
  dim_t sw, sh, dw, dh, ds, cw, ch;
  always_comb begin
    sw = clamp_dim(src_cols);
    sh = clamp_dim(src_height);
    dw = clamp_dim(dst_width);
    dh = clamp_dim(dst_height);
    ds = clamp_dim(dst_stride);
    cw = (sw < dw) ? sw : dw;
    ch = (sh < dh) ? sh : dh;
  end

  logic [2:0]       state;
  logic [CNT_W-1:0] column_count, row_count;
  logic [CNT_W-1:0] col_cur, row_cur;
  logic [2:0]       pend;
  logic             eof_q;
  logic [STAT_W-1:0] stat_q;
  logic [7:0]       chan [3];
  logic [7:0]       alpha;
  logic [1:0]       ch_idx;
  logic [7:0]       rem, nlo;
  logic [6:0]       quot;
  logic [2:0]       step;
  logic [2*DIM_W-1:0] row_base, bot_off, bot_run;

  // Output register.
  logic                out_valid, out_last;
  logic [TDATA_W-1:0]  out_data;
  logic [TUSER_W-1:0]  out_user;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_user;
  assign m_tlast  = out_last;

  // Position decode for the pixel being taken.
  logic in_take, row_end, eof_in, err_stride, err_fmt, wr_en, rf_en, bf_en;
  always_comb begin
    in_take    = s_tvalid && s_tready;
    row_end    = ({1'b0, column_count} + dim_t'(1)) >= sw;
    eof_in     = row_end && (({1'b0, row_count} + dim_t'(1)) >= sh);
    err_stride = ds < dw;
    err_fmt    = pixel_format == FMT_BAD;
    wr_en      = ({1'b0, row_count} < ch) && ({1'b0, column_count} < cw);
    rf_en      = row_end && ({1'b0, row_count} < ch) && (cw < ds);
    bf_en      = eof_in && (ch < dh);
  end

  // Shared multiplier for the three address products.
  dim_t mul_a, mul_b;
  logic [2*DIM_W-1:0] mul_p;
  always_comb begin
    case (state)
      ST_MUL0: mul_a = {1'b0, row_cur};
      ST_MUL1: mul_a = ch;
      default: mul_a = dh - ch;
    endcase
    mul_b = ds;
    mul_p = mul_a * mul_b;
  end

  // Shared divider datapath: one restoring step or a saturation check.
  logic [7:0]  dv_c;
  logic [15:0] dv_n;
  logic [8:0]  trial, diff;
  logic        ge, need_div;
  always_comb begin
    dv_c     = chan[ch_idx];
    dv_n     = {dv_c, 8'd0} - {8'd0, dv_c};
    trial    = {rem, nlo[7]};
    diff     = trial - {1'b0, alpha};
    ge       = trial >= {1'b0, alpha};
    need_div = (pixel_format == FMT_RGB565) && (alpha != 8'd0) && (alpha != 8'hFF)
               && (stat_q == STAT_OK);
  end

  // Selection of the next pending result, lowest kind first.
  logic [2:0]          pick, pend_after;
  logic [OFF_W-1:0]    res_off;
  logic [DATA_W-1:0]   res_data, conv;
  logic [RUN_W-1:0]    res_run;
  always_comb begin
    case (pixel_format)
      FMT_RGBA: conv = {alpha, chan[2], chan[1], chan[0]};
      FMT_RGBX: conv = {8'hFF, chan[2], chan[1], chan[0]};
      default:  conv = {16'd0, chan[0][7:3], chan[1][7:2], chan[2][7:3]};
    endcase
    pick       = pend & (~pend + 3'd1);
    pend_after = pend & ~pick;
    res_off    = '0;
    res_data   = '0;
    res_run    = '0;
    if (stat_q == STAT_OK) begin
      if (pick[0]) begin
        res_off  = row_base[OFF_W-1:0] + OFF_W'(col_cur);
        res_data = conv;
        res_run  = RUN_W'(1);
      end else if (pick[1]) begin
        res_off  = row_base[OFF_W-1:0] + OFF_W'(cw);
        res_run  = RUN_W'(ds - cw);
      end else begin
        res_off  = bot_off[OFF_W-1:0];
        res_run  = bot_run[RUN_W-1:0];
      end
    end
  end

  // Sequencer, counters and divider registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      column_count <= '0;
      row_count    <= '0;
      pend         <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            col_cur <= column_count;
            row_cur <= row_count;
            eof_q   <= eof_in;
            chan[0] <= s_tdata[7:0];
            chan[1] <= s_tdata[15:8];
            chan[2] <= s_tdata[23:16];
            alpha   <= s_tdata[31:24];
            ch_idx  <= '0;
            if (err_stride) begin
              stat_q <= STAT_BAD_STRIDE;
            end else if (err_fmt) begin
              stat_q <= STAT_BAD_FORMAT;
            end else begin
              stat_q <= STAT_OK;
            end
            pend <= (err_stride || err_fmt) ? 3'b001 : {bf_en, rf_en, wr_en};
            if (row_end) begin
              column_count <= '0;
              row_count    <= (({1'b0, row_count} + dim_t'(1)) >= sh) ? '0
                              : row_count + CNT_W'(1);
            end else begin
              column_count <= column_count + CNT_W'(1);
            end
            state <= ST_MUL0;
          end
        end
        ST_MUL0: begin
          row_base <= mul_p;
          state    <= ST_MUL1;
        end
        ST_MUL1: begin
          bot_off <= mul_p;
          state   <= ST_MUL2;
        end
        ST_MUL2: begin
          bot_run <= mul_p;
          state   <= need_div ? ST_DLOAD : ST_EMIT;
        end
        ST_DLOAD: begin
          // A colour at or above alpha saturates the quotient.
          if (dv_c >= alpha) begin
            chan[ch_idx] <= 8'hFF;
            if (ch_idx == 2'd2) begin
              state <= ST_EMIT;
            end else begin
              ch_idx <= ch_idx + 2'd1;
            end
          end else begin
            rem   <= dv_n[15:8];
            nlo   <= dv_n[7:0];
            step  <= '0;
            state <= ST_DSTEP;
          end
        end
        ST_DSTEP: begin
          rem  <= ge ? diff[7:0] : trial[7:0];
          nlo  <= {nlo[6:0], 1'b0};
          quot <= {quot[5:0], ge};
          step <= step + 3'd1;
          if (step == 3'd7) begin
            chan[ch_idx] <= {quot, ge};
            if (ch_idx == 2'd2) begin
              state <= ST_EMIT;
            end else begin
              ch_idx <= ch_idx + 2'd1;
              state  <= ST_DLOAD;
            end
          end
        end
        ST_EMIT: begin
          if (pend == '0) begin
            state <= ST_IDLE;
          end else if (!out_valid || m_tready) begin
            pend <= pend_after;
            if (pend_after == '0) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register control.
  logic out_load;
  assign out_load = (state == ST_EMIT) && (pend != '0) && (!out_valid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= {(TDATA_W - OUT_BITS)'(0), res_run, res_data, res_off};
      out_user <= {eof_q, stat_q};
      out_last <= (pend_after == '0);
    end
  end

endmodule

`default_nettype wire

### rtl/rbfc_checker.sv
// ---------------------------------------------------------------------------
// Raster blit port checker
// Watches the ports of the blit unit for result and handshake consistency.
// ---------------------------------------------------------------------------
`default_nettype none

`include "raster_blit_format_convert_unit_macros.svh"

module rbfc_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_tvalid,
  input wire logic                             s_tready,
  input wire logic                             m_tvalid,
  input wire logic                             m_tready,
  input wire logic [rbfc_pkg::TDATA_W-1:0]     m_tdata,
  input wire logic [rbfc_pkg::TUSER_W-1:0]     m_tuser,
  input wire logic                             m_tlast
);
  import rbfc_pkg::*;

  logic [RUN_W-1:0]  run;
  logic [STAT_W-1:0] stat;
  assign run  = m_tdata[RUN_LSB +: RUN_W];
  assign stat = m_tuser[STAT_W-1:0];

  // A stalled result holds its payload.
  `RBFC_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

  // An error result is alone, has no run and carries the last mark.
  `RBFC_ASSERT_NOW(a_err_result, m_tvalid && (stat != STAT_OK), (run == '0) && m_tlast)

  // A good result always writes at least one pixel.
  `RBFC_ASSERT_NOW(a_ok_run, m_tvalid && (stat == STAT_OK), run != '0)

  // The unit works on one pixel at a time.
  `RBFC_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)

endmodule

bind raster_blit_format_convert_unit rbfc_checker u_rbfc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

### tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// Raster blit format converter testbench
// Streams source pixels into the blit unit under a range of geometry and
// format settings, predicts every destination write and zero-fill run, and
// compares each output request field by field, with random stalls on both
// streams and one long output stall.
// ---------------------------------------------------------------------------
module testbench;
  import rbfc_pkg::*;

  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_ITEMS = 190;

  // One destination write or fill, as carried by the output stream.
  typedef struct packed {
    logic [OFF_W-1:0]  off;
    logic [DATA_W-1:0] data;
    logic [RUN_W-1:0]  run;
    logic [STAT_W-1:0] status;
    logic              eof;
    logic              last;
  } dst_write_t;

  // One row of the directed stimulus: a register write or a pixel.
  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] value;
    logic [PIX_W-1:0]      px;
    bit                    typed;
    dst_write_t            want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [PIX_W-1:0]      s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [TDATA_W-1:0]    m_tdata;
  logic [TUSER_W-1:0]    m_tuser;
  logic                  m_tlast;

  // Shadow copy of the registers and the frame position.
  logic [1:0]       fmt_q = FMT_RGBA;
  dim_t             src_w_q = dim_t'(1);
  dim_t             src_h_q = dim_t'(1);
  dim_t             dst_w_q = dim_t'(1);
  dim_t             dst_h_q = dim_t'(1);
  dim_t             stride_q = dim_t'(1);
  logic [CNT_W-1:0] col_pos = '0;
  logic [CNT_W-1:0] row_pos = '0;

  dst_write_t pending_writes[$];
  stim_row_t  plan[$];

  int errors = 0;
  int pixels_sent = 0;
  int writes_checked = 0;
  int settings_used = 0;
  bit calm = 1'b0;
  bit hold_off_req = 1'b0;

  raster_blit_format_convert_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Sizes outside 1 to MAX_DIM are saturated before use.
  function automatic int unsigned sat_dim(input dim_t v);
    if (v == '0) begin
      return 1;
    end
    if (v > dim_t'(MAX_DIM)) begin
      return MAX_DIM;
    end
    return 32'(v);
  endfunction

  // Undo premultiplied alpha with truncation, saturating at full scale.
  function automatic logic [7:0] unpremultiply(input logic [7:0] c, input logic [7:0] a);
    int unsigned q;
    q = (int'(c) * 255) / int'(a);
    return (q > 255) ? 8'hFF : q[7:0];
  endfunction

  function automatic logic [DATA_W-1:0] convert_pixel(input logic [1:0] fmt,
                                                      input logic [PIX_W-1:0] px);
    logic [7:0] r, g, b, a;
    r = px[7:0];
    g = px[15:8];
    b = px[23:16];
    a = px[31:24];
    case (fmt)
      FMT_RGBA: begin
        return px;
      end
      FMT_RGBX: begin
        return px | 32'hFF00_0000;
      end
      default: begin
        if (a != 8'h00 && a != 8'hFF) begin
          r = unpremultiply(r, a);
          g = unpremultiply(g, a);
          b = unpremultiply(b, a);
        end
        return {16'h0000, r[7:3], g[7:2], b[7:3]};
      end
    endcase
  endfunction

  function automatic dst_write_t make_write(input int unsigned off, input logic [DATA_W-1:0] data,
                                            input int unsigned run, input logic [STAT_W-1:0] status,
                                            input bit eof);
    dst_write_t w;
    w.off    = OFF_W'(off);
    w.data   = data;
    w.run    = RUN_W'(run);
    w.status = status;
    w.eof    = eof;
    w.last   = 1'b0;
    return w;
  endfunction

  // Work out the writes and fills caused by one source pixel and advance
  // the frame position.
  task automatic predict_writes(input logic [PIX_W-1:0] px, output dst_write_t res[3],
                                output int cnt);
    int unsigned sw, sh, dw, dh, ds, cw, ch, col, row;
    bit row_end, eof;
    sw = sat_dim(src_w_q);
    sh = sat_dim(src_h_q);
    dw = sat_dim(dst_w_q);
    dh = sat_dim(dst_h_q);
    ds = sat_dim(stride_q);
    cw = (sw < dw) ? sw : dw;
    ch = (sh < dh) ? sh : dh;
    col = col_pos;
    row = row_pos;
    row_end = (col + 1 >= sw);
    eof = row_end && (row + 1 >= sh);
    cnt = 0;
    if (ds < dw || fmt_q == FMT_BAD) begin
      res[0] = make_write(0, '0, 0, (ds < dw) ? STAT_BAD_STRIDE : STAT_BAD_FORMAT, eof);
      cnt = 1;
    end else begin
      if (row < ch && col < cw) begin
        res[cnt] = make_write(row * ds + col, convert_pixel(fmt_q, px), 1, STAT_OK, eof);
        cnt++;
      end
      if (row_end && row < ch && cw < ds) begin
        res[cnt] = make_write(row * ds + cw, '0, ds - cw, STAT_OK, eof);
        cnt++;
      end
      if (eof && ch < dh) begin
        res[cnt] = make_write(ch * ds, '0, (dh - ch) * ds, STAT_OK, eof);
        cnt++;
      end
    end
    if (cnt > 0) begin
      res[cnt-1].last = 1'b1;
    end
    if (row_end) begin
      col_pos = '0;
      row_pos = (row + 1 >= sh) ? '0 : CNT_W'(row + 1);
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endtask

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  function automatic void plan_cfg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] value);
    stim_row_t r;
    r = '{is_cfg: 1'b1, idx: idx, value: value, px: '0, typed: 1'b0, want: '0};
    plan.push_back(r);
  endfunction

  function automatic void plan_pixel(input logic [PIX_W-1:0] px);
    stim_row_t r;
    r = '{is_cfg: 1'b0, idx: '0, value: '0, px: px, typed: 1'b0, want: '0};
    plan.push_back(r);
  endfunction

  // A pixel whose single result is written out by hand.
  function automatic void plan_pixel_write(input logic [PIX_W-1:0] px, input int unsigned off,
                                           input logic [DATA_W-1:0] data, input int unsigned run,
                                           input logic [STAT_W-1:0] status, input bit eof);
    stim_row_t r;
    r = '{is_cfg: 1'b0, idx: '0, value: '0, px: px, typed: 1'b1, want: '0};
    r.want = make_write(off, data, run, status, eof);
    r.want.last = 1'b1;
    plan.push_back(r);
  endfunction

  function automatic logic [PIX_W-1:0] random_pixel();
    logic [7:0] a;
    case ($urandom_range(0, 5))
      0: a = 8'h00;
      1: a = 8'hFF;
      2: a = 8'h01;
      3: a = 8'hFE;
      default: a = 8'($urandom_range(0, 255));
    endcase
    return {a, 24'($urandom)};
  endfunction

  // Register writes happen only while the unit is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FORMAT:     fmt_q = value[1:0];
      REG_SRC_WIDTH:  src_w_q = value;
      REG_SRC_HEIGHT: src_h_q = value;
      REG_DST_WIDTH:  dst_w_q = value;
      REG_DST_HEIGHT: dst_h_q = value;
      REG_DST_STRIDE: stride_q = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Stop offering pixels until every expected write has come back and the
  // unit has had time to finish a pixel that causes no write.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_writes.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Offer one pixel; valid stays high on return so that a following pixel
  // with no gap goes out back to back.
  task automatic send_pixel(input logic [PIX_W-1:0] px, input bit typed, input dst_write_t want);
    int gap;
    int cnt;
    dst_write_t res[3];
    gap = draw_wait();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    do @(posedge clk); while (!s_tready);
    predict_writes(px, res, cnt);
    if (typed) begin
      pending_writes.push_back(want);
    end else begin
      for (int i = 0; i < cnt; i++) begin
        pending_writes.push_back(res[i]);
      end
    end
    pixels_sent++;
  endtask

  // Output side: random stalls, one long hold-off on request, and a check
  // of every accepted request against the oldest expected write.
  initial begin : write_sink
    int stall;
    dst_write_t got;
    dst_write_t want;
    forever begin
      stall = hold_off_req ? HOLD_CYCLES : draw_wait();
      hold_off_req = 1'b0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got.off    = m_tdata[OFF_LSB +: OFF_W];
      got.data   = m_tdata[DATA_LSB +: DATA_W];
      got.run    = m_tdata[RUN_LSB +: RUN_W];
      got.status = m_tuser[STAT_W-1:0];
      got.eof    = m_tuser[STAT_W];
      got.last   = m_tlast;
      writes_checked++;
      if (pending_writes.size() == 0) begin
        $error("unexpected write: offset 0x%0h, data 0x%0h, run %0d", got.off, got.data,
               got.run);
        errors++;
      end else begin
        want = pending_writes.pop_front();
        check_field("dst_offset", 32'(want.off), 32'(got.off));
        check_field("pixel_data", want.data, got.data);
        check_field("run_length", 32'(want.run), 32'(got.run));
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("end_of_frame", 32'(want.eof), 32'(got.eof));
        check_field("last_result", 32'(want.last), 32'(got.last));
      end
    end
  end

  initial begin : run_limit
    #(LIMIT_CYCLES * 8);
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int n_random;
    int phase;
    int items;
    logic [12:0] fmt_v, sw, sh, dw, dh, ds;
    dst_write_t no_write;

    no_write = '0;
    n_random = 0;
    phase = 0;

    // Reset values, then the three formats with alpha extremes.
    plan_pixel_write(32'h0403_0201, 0, 32'h0403_0201, 1, STAT_OK, 1'b1);
    plan_pixel_write(32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 1, STAT_OK, 1'b1);
    plan_cfg(REG_FORMAT, 13'(FMT_RGBX));
    plan_pixel_write(32'h0000_0000, 0, 32'hFF00_0000, 1, STAT_OK, 1'b1);
    plan_cfg(REG_FORMAT, 13'(FMT_RGB565));
    plan_pixel_write(32'hFFFF_FFFF, 0, 32'h0000_FFFF, 1, STAT_OK, 1'b1);
    plan_pixel_write(32'h00FF_FFFF, 0, 32'h0000_FFFF, 1, STAT_OK, 1'b1);
    plan_pixel_write(32'h0101_0101, 0, 32'h0000_FFFF, 1, STAT_OK, 1'b1);
    plan_pixel_write(32'h0000_0000, 0, 32'h0000_0000, 1, STAT_OK, 1'b1);
    plan_pixel(32'hFE80_8080);
    plan_pixel(32'h80FF_4020);
    plan_pixel(32'h7F10_2030);
    // Unsupported format; then a short stride, which takes precedence.
    plan_cfg(REG_FORMAT, 13'(FMT_BAD));
    plan_pixel_write(32'h1234_5678, 0, '0, 0, STAT_BAD_FORMAT, 1'b1);
    plan_cfg(REG_DST_WIDTH, 13'd4);
    plan_pixel_write(32'h8765_4321, 0, '0, 0, STAT_BAD_STRIDE, 1'b1);
    // Out-of-range sizes saturate: width 8191 and stride 0.
    plan_cfg(REG_FORMAT, 13'(FMT_RGBA));
    plan_cfg(REG_DST_WIDTH, 13'h1FFF);
    plan_cfg(REG_DST_STRIDE, 13'd0);
    plan_pixel_write(32'hDEAD_BEEF, 0, '0, 0, STAT_BAD_STRIDE, 1'b1);
    // Largest destination: pixel, row fill and bottom fill from one pixel.
    plan_cfg(REG_DST_WIDTH, 13'd4096);
    plan_cfg(REG_DST_STRIDE, 13'd4096);
    plan_cfg(REG_DST_HEIGHT, 13'd4096);
    plan_pixel(32'hA5A5_A5A5);
    // Tall source, then the height shrinks under the row counter mid-frame.
    plan_cfg(REG_SRC_WIDTH, 13'd0);
    plan_cfg(REG_SRC_HEIGHT, 13'h1FFF);
    plan_pixel(32'h5A5A_5A5A);
    plan_pixel(32'h0F0F_0F0F);
    plan_cfg(REG_SRC_HEIGHT, 13'd2);
    plan_pixel(32'hF0F0_F0F0);
    // Pixels right of the window are dropped without any write.
    plan_cfg(REG_DST_WIDTH, 13'd1);
    plan_cfg(REG_DST_HEIGHT, 13'd1);
    plan_cfg(REG_DST_STRIDE, 13'd1);
    plan_cfg(REG_SRC_WIDTH, 13'd3);
    plan_cfg(REG_SRC_HEIGHT, 13'd1);
    plan_pixel_write(32'h1122_3344, 0, 32'h1122_3344, 1, STAT_OK, 1'b0);
    plan_pixel(32'h5566_7788);
    plan_pixel(32'h99AA_BBCC);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].idx, plan[i].value);
        settings_used++;
      end else begin
        send_pixel(plan[i].px, plan[i].typed, plan[i].want);
      end
    end

    // Random settings, mostly small frames so that rows and frames close.
    while (n_random < RANDOM_ITEMS) begin
      settle();
      phase++;
      calm = ($urandom_range(0, 3) == 0);
      fmt_v = ($urandom_range(0, 7) == 0) ? 13'(FMT_BAD) : 13'($urandom_range(0, 2));
      sw = 13'($urandom_range(1, 5));
      sh = 13'($urandom_range(1, 4));
      dw = 13'($urandom_range(1, 6));
      dh = 13'($urandom_range(1, 5));
      if ($urandom_range(0, 7) == 0 && dw > 1) begin
        ds = 13'($urandom_range(1, dw - 1));
      end else begin
        ds = 13'(dw + $urandom_range(0, 3));
      end
      case ($urandom_range(0, 11))
        0: sw = 13'd0;
        1: dh = 13'($urandom_range(4097, 8191));
        2: ds = 13'd0;
        3: sh = 13'($urandom_range(4097, 8191));
        default: ;
      endcase
      write_reg(REG_FORMAT, fmt_v);
      write_reg(REG_SRC_WIDTH, sw);
      write_reg(REG_SRC_HEIGHT, sh);
      write_reg(REG_DST_WIDTH, dw);
      write_reg(REG_DST_HEIGHT, dh);
      write_reg(REG_DST_STRIDE, ds);
      settings_used++;
      items = sat_dim(sw) * sat_dim(sh) * $urandom_range(1, 2);
      items = ((items > 24) ? 24 : items) + $urandom_range(0, 2);
      if (phase == 3) begin
        // Long output stall while pixels keep coming back to back.
        calm = 1'b1;
        hold_off_req = 1'b1;
        items = 12;
      end
      repeat (items) begin
        send_pixel(random_pixel(), 1'b0, no_write);
        n_random++;
      end
    end

    settle();
    $display("summary: %0d pixels (%0d random) under %0d register settings, %0d writes checked",
             pixels_sent, n_random, settings_used, writes_checked);
    $display("summary: all formats, bad stride and format, saturated sizes, mid-frame resizing");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### raster_blit_format_convert_unit.f
+incdir+rtl
rtl/rbfc_pkg.sv
rtl/raster_blit_format_convert_unit.sv
rtl/rbfc_checker.sv
tb/sv/testbench.sv
